/* sv/cpr_pkg.sv */
// ----------------------------------------------------------------------------
// cpr_pkg
// Shared types, sizes and helpers for the clock page replacement core.
// ----------------------------------------------------------------------------
package cpr_pkg;

   localparam int NUM_FRAMES = 64;
   localparam int PAGE_BITS  = 20;
   localparam int IDX_W      = $clog2(NUM_FRAMES);
   localparam int CNT_W      = $clog2(NUM_FRAMES + 1);

   // field widths fixed by the interface
   localparam int PAGE_FIELD_W = 20;
   localparam int FIDX_W       = 6;
   localparam int FIU_W        = 7;
   localparam int CSR_DATA_W   = 7;
   localparam int CSR_IDX_W    = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_ENHANCED_MODE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAMES_IN_USE = 1'd1;

   localparam logic [FIU_W-1:0] FIU_RESET = 7'd64;

   typedef struct packed {
      logic [PAGE_FIELD_W-1:0] page_number;
      logic                    is_write;
   } req_type;

   typedef struct packed {
      logic                    hit;
      logic [FIDX_W-1:0]       frame_index;
      logic                    evicted;
      logic [PAGE_FIELD_W-1:0] victim_page;
      logic                    victim_dirty;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic scan;
      logic commit_hit;
      logic commit_free;
      logic vic_init;
      logic vic_step;
      logic commit_victim;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic done;
      logic hit;
      logic free;
      logic vic_stop;
   } sts_type;

   // ring successor of a frame index
   function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx,
                                                 input logic [CNT_W-1:0] n);
      logic [CNT_W-1:0] inc;
      inc = CNT_W'(idx) + 1'b1;
      return (inc >= n) ? '0 : inc[IDX_W-1:0];
   endfunction

endpackage

/* sv/clock_page_replacement_core.sv */
// ----------------------------------------------------------------------------
// clock_page_replacement_core
// Clock page replacement with optional enhanced (ref, mod) victim choice.
//
//   channel   direction   handshake                payload
//   req_      in          req_valid / req_ready    req_data (page, write flag)
//   rsp_      out         rsp_valid / rsp_ready    rsp_data (hit, frame, victim)
//   csr_      in          csr_we                   csr_index, csr_wdata
//
// One access at a time. The lookup reads the frame table one entry a cycle
// and stops early when a hit turns up; a full-ring miss then walks the hand
// frame by frame (one ring pass in plain mode, up to three in enhanced mode).
// Reset clears all frame flags and the hand; the frame table needs no clearing.
// A waiting result word does not block the next request from being taken.
// ----------------------------------------------------------------------------
module clock_page_replacement_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  cpr_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output cpr_pkg::rsp_type                  rsp_data,
   input  logic                              csr_we,
   input  logic [cpr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [cpr_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   cpr_pkg::cmd_type cmd;
   cpr_pkg::sts_type sts;

   cpr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   cpr_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule

/* sv/cpr_ctrl.sv */
// ----------------------------------------------------------------------------
// cpr_ctrl
// Sequencer: lookup scan, victim walk, commit and result handoff.
// ----------------------------------------------------------------------------
module cpr_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output cpr_pkg::cmd_type cmd,
   input  cpr_pkg::sts_type sts
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_VICTIM,
      ST_FILL
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;
   logic      commit;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign commit    = cmd.commit_hit || cmd.commit_free || cmd.commit_victim;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.done) begin
               if (sts.hit) begin
                  if (out_free) begin
                     cmd.commit_hit = 1'b1;
                     state_in       = ST_IDLE;
                  end
               end else if (sts.free) begin
                  if (out_free) begin
                     cmd.commit_free = 1'b1;
                     state_in        = ST_IDLE;
                  end
               end else begin
                  cmd.vic_init = 1'b1;
                  state_in     = ST_VICTIM;
               end
            end
         end
         ST_VICTIM: begin
            cmd.vic_step = 1'b1;
            if (sts.vic_stop) begin
               state_in = ST_FILL;
            end
         end
         ST_FILL: begin
            if (out_free) begin
               cmd.commit_victim = 1'b1;
               state_in          = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // a result word is never overwritten before it is taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !commit)
      else $error("result overwritten");

   // the walk only begins after a scan that found neither hit nor free frame
   a_walk_entry: assert property (@(posedge clock) disable iff (reset)
      cmd.vic_init |-> (sts.done && !sts.hit && !sts.free))
      else $error("victim walk without full ring");

   // a commit always returns to idle
   a_commit_idle: assert property (@(posedge clock) disable iff (reset)
      commit |=> (state_ff == ST_IDLE))
      else $error("commit did not return to idle");

endmodule

/* sv/cpr_dp.sv */
// ----------------------------------------------------------------------------
// cpr_dp
// Frame table, flag vectors, clock hand, lookup pipeline and victim walk.
// ----------------------------------------------------------------------------
module cpr_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [cpr_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [cpr_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  cpr_pkg::req_type                     req_data,
   output cpr_pkg::rsp_type                     rsp_data,
   input  cpr_pkg::cmd_type                     cmd,
   output cpr_pkg::sts_type                     sts
);

   localparam int NF    = cpr_pkg::NUM_FRAMES;
   localparam int IDX_W = cpr_pkg::IDX_W;
   localparam int CNT_W = cpr_pkg::CNT_W;
   localparam int PB    = cpr_pkg::PAGE_BITS;

   // configuration
   logic                       enh_ff;
   logic [cpr_pkg::FIU_W-1:0]  fiu_ff;
   logic [CNT_W-1:0]           ring_n;

   // frame table and flags
   logic [PB-1:0]              page_mem [NF];
   logic [NF-1:0]              valid_ff, valid_in;
   logic [NF-1:0]              ref_ff, ref_in;
   logic [NF-1:0]              mod_ff, mod_in;
   logic [IDX_W-1:0]           hand_ff, hand_in, hand_norm;

   // request held during the operation
   logic [PB-1:0]              page_ff;
   logic                       wr_ff;

   // lookup scan
   logic [IDX_W-1:0]           ptr_ff, ptr_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic                       d_valid_ff, d_valid_in;
   logic [IDX_W-1:0]           d_idx_ff, d_idx_in;
   logic                       d_last_ff, d_last_in;
   logic [PB-1:0]              rdata_ff;
   logic                       done_ff, done_in;
   logic                       hit_ff, hit_in;
   logic [IDX_W-1:0]           hit_idx_ff, hit_idx_in;
   logic                       free_ff, free_in;
   logic [IDX_W-1:0]           free_idx_ff, free_idx_in;
   logic                       issue;
   logic [IDX_W-1:0]           rd_addr;

   // victim walk
   logic [2:0]                 phase_ff, phase_in;
   logic [CNT_W-1:0]           k_ff, k_in;
   logic                       ref_h, mod_h, vic_stop;

   // table write
   logic                       mem_we;
   logic [IDX_W-1:0]           mem_waddr;

   cpr_pkg::rsp_type           rsp_ff, rsp_in;

   // ring size with out-of-range values clamped
   always_comb begin
      if (fiu_ff == '0) begin
         ring_n = CNT_W'(1);
      end else if (CNT_W'(fiu_ff) > CNT_W'(NF)) begin
         ring_n = CNT_W'(NF);
      end else begin
         ring_n = CNT_W'(fiu_ff);
      end
   end

   assign hand_norm = (CNT_W'(hand_ff) >= ring_n) ? '0 : hand_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         enh_ff <= 1'b0;
         fiu_ff <= cpr_pkg::FIU_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            cpr_pkg::CSR_ENHANCED_MODE: enh_ff <= csr_wdata[0];
            cpr_pkg::CSR_FRAMES_IN_USE: fiu_ff <= csr_wdata[cpr_pkg::FIU_W-1:0];
            default: ;
         endcase
      end
   end

   // lookup: one read issued per cycle, compared in the next cycle
   assign issue   = cmd.scan && !done_ff && (cnt_ff != ring_n);
   assign rd_addr = cmd.scan ? ptr_ff : hand_ff;

   always_comb begin
      ptr_in      = ptr_ff;
      cnt_in      = cnt_ff;
      d_valid_in  = issue;
      d_idx_in    = ptr_ff;
      d_last_in   = (cnt_ff + 1'b1) == ring_n;
      done_in     = done_ff;
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      free_in     = free_ff;
      free_idx_in = free_idx_ff;
      if (cmd.load) begin
         ptr_in     = hand_norm;
         cnt_in     = '0;
         d_valid_in = 1'b0;
         done_in    = 1'b0;
         hit_in     = 1'b0;
         free_in    = 1'b0;
      end else begin
         if (issue) begin
            ptr_in = cpr_pkg::next_idx(ptr_ff, ring_n);
            cnt_in = cnt_ff + 1'b1;
         end
         if (d_valid_ff && !done_ff) begin
            if (valid_ff[d_idx_ff] && (rdata_ff == page_ff)) begin
               hit_in     = 1'b1;
               hit_idx_in = d_idx_ff;
               done_in    = 1'b1;
            end else begin
               if (!valid_ff[d_idx_ff] && !free_ff) begin
                  free_in     = 1'b1;
                  free_idx_in = d_idx_ff;
               end
               if (d_last_ff) begin
                  done_in = 1'b1;
               end
            end
         end
      end
   end

   // victim choice at the hand
   assign ref_h = ref_ff[hand_ff];
   assign mod_h = mod_ff[hand_ff];

   always_comb begin
      if (!enh_ff) begin
         vic_stop = !ref_h;
      end else if (phase_ff[2]) begin
         vic_stop = 1'b1;
      end else if (!phase_ff[0]) begin
         vic_stop = !ref_h && !mod_h;
      end else begin
         vic_stop = !ref_h && mod_h;
      end
   end

   always_comb begin
      hand_in   = hand_ff;
      phase_in  = phase_ff;
      k_in      = k_ff;
      valid_in  = valid_ff;
      ref_in    = ref_ff;
      mod_in    = mod_ff;
      mem_we    = 1'b0;
      mem_waddr = hand_ff;
      rsp_in    = rsp_ff;
      if (cmd.load) begin
         hand_in = hand_norm;
      end
      if (cmd.vic_init) begin
         phase_in = '0;
         k_in     = '0;
      end
      if (cmd.vic_step && !vic_stop) begin
         // plain mode and the modified pass take away the second chance
         if (!enh_ff || (phase_ff[0] && ref_h)) begin
            ref_in[hand_ff] = 1'b0;
         end
         hand_in = cpr_pkg::next_idx(hand_ff, ring_n);
         if ((k_ff + 1'b1) == ring_n) begin
            k_in     = '0;
            phase_in = phase_ff + 1'b1;
         end else begin
            k_in = k_ff + 1'b1;
         end
      end
      if (cmd.commit_hit) begin
         ref_in[hit_idx_ff] = 1'b1;
         if (wr_ff) begin
            mod_in[hit_idx_ff] = 1'b1;
         end
         rsp_in             = '0;
         rsp_in.hit         = 1'b1;
         rsp_in.frame_index = cpr_pkg::FIDX_W'(hit_idx_ff);
      end
      if (cmd.commit_free || cmd.commit_victim) begin
         mem_we             = 1'b1;
         mem_waddr          = cmd.commit_free ? free_idx_ff : hand_ff;
         valid_in[mem_waddr] = 1'b1;
         ref_in[mem_waddr]  = 1'b1;
         mod_in[mem_waddr]  = wr_ff;
         rsp_in             = '0;
         rsp_in.frame_index = cpr_pkg::FIDX_W'(mem_waddr);
         if (cmd.commit_victim) begin
            rsp_in.evicted      = 1'b1;
            rsp_in.victim_page  = cpr_pkg::PAGE_FIELD_W'(rdata_ff);
            rsp_in.victim_dirty = mod_h;
         end
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= page_mem[rd_addr];
      if (mem_we) begin
         page_mem[mem_waddr] <= page_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         ref_ff     <= '0;
         mod_ff     <= '0;
         hand_ff    <= '0;
         d_valid_ff <= 1'b0;
         done_ff    <= 1'b0;
         hit_ff     <= 1'b0;
         free_ff    <= 1'b0;
      end else begin
         valid_ff   <= valid_in;
         ref_ff     <= ref_in;
         mod_ff     <= mod_in;
         hand_ff    <= hand_in;
         d_valid_ff <= d_valid_in;
         done_ff    <= done_in;
         hit_ff     <= hit_in;
         free_ff    <= free_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         page_ff <= req_data.page_number[PB-1:0];
         wr_ff   <= req_data.is_write;
      end
      ptr_ff      <= ptr_in;
      cnt_ff      <= cnt_in;
      d_idx_ff    <= d_idx_in;
      d_last_ff   <= d_last_in;
      hit_idx_ff  <= hit_idx_in;
      free_idx_ff <= free_idx_in;
      phase_ff    <= phase_in;
      k_ff        <= k_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_data     = rsp_ff;
   assign sts.done     = done_ff;
   assign sts.hit      = hit_ff;
   assign sts.free     = free_ff;
   assign sts.vic_stop = vic_stop;

   // after a request is taken the hand lies inside the ring
   a_hand_in_ring: assert property (@(posedge clock) disable iff (reset)
      $past(cmd.load) |-> (CNT_W'(hand_ff) < ring_n))
      else $error("hand outside ring");

   // a free fill only lands on an empty frame
   a_free_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.commit_free |-> (free_ff && !valid_ff[free_idx_ff]))
      else $error("free fill on occupied frame");

   // a victim is always a resident frame
   a_victim_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.commit_victim |-> valid_ff[hand_ff])
      else $error("victim frame not resident");

endmodule

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for clock_page_replacement_core. A behavioral copy of
// the clock ring (plain second chance and enhanced ref/mod passes) predicts
// every result word. Directed accesses cover reset settings, ring shrink,
// out-of-range ring sizes and both victim passes. Random phases then run
// with several ring sizes, modes and idle patterns, plus one long receiver
// hold-off.
// ----------------------------------------------------------------------------

class replacement_tracker;

   logic [cpr_pkg::PAGE_FIELD_W-1:0] page_at [cpr_pkg::NUM_FRAMES];
   bit                               occupied [cpr_pkg::NUM_FRAMES];
   bit                               referenced [cpr_pkg::NUM_FRAMES];
   bit                               modified [cpr_pkg::NUM_FRAMES];
   int                               hand = 0;
   bit                               enhanced = 1'b0;
   logic [cpr_pkg::FIU_W-1:0]        ring_reg = cpr_pkg::FIU_RESET;

   cpr_pkg::rsp_type                 expected_outcomes [$];
   int unsigned                      errors = 0;
   int unsigned                      n_checked = 0;
   int unsigned                      n_hits = 0;
   int unsigned                      n_evicted = 0;
   int unsigned                      n_dirty = 0;

   function new();
      for (int i = 0; i < cpr_pkg::NUM_FRAMES; i++) begin
         page_at[i]    = '0;
         occupied[i]   = 1'b0;
         referenced[i] = 1'b0;
         modified[i]   = 1'b0;
      end
   endfunction

   function void apply_reg(logic [cpr_pkg::CSR_IDX_W-1:0] idx,
                           logic [cpr_pkg::CSR_DATA_W-1:0] val);
      if (idx == cpr_pkg::CSR_ENHANCED_MODE) begin
         enhanced = val[0];
      end else if (idx == cpr_pkg::CSR_FRAMES_IN_USE) begin
         ring_reg = val[cpr_pkg::FIU_W-1:0];
      end
   endfunction

   function int ring_len();
      if (ring_reg == 0) return 1;
      if (ring_reg > cpr_pkg::NUM_FRAMES) return cpr_pkg::NUM_FRAMES;
      return int'(ring_reg);
   endfunction

   function int succ(int f, int n);
      return (f + 1 >= n) ? 0 : f + 1;
   endfunction

   // second chance: clear ref bits until the hand sits on a clear one
   function void walk_plain(int n);
      bit done;
      done = 1'b0;
      for (int g = 0; g <= n; g++) begin
         if (!done) begin
            if (!referenced[hand]) begin
               done = 1'b1;
            end else begin
               referenced[hand] = 1'b0;
               hand = succ(hand, n);
            end
         end
      end
   endfunction

   // pass a looks for (0,0) untouched, pass b for (0,1) clearing refs on the way
   function void walk_enhanced(int n);
      bit done;
      done = 1'b0;
      for (int r = 0; r < 2; r++) begin
         for (int k = 0; k < n; k++) begin
            if (!done) begin
               if (!referenced[hand] && !modified[hand]) done = 1'b1;
               else hand = succ(hand, n);
            end
         end
         for (int k = 0; k < n; k++) begin
            if (!done) begin
               if (referenced[hand]) begin
                  referenced[hand] = 1'b0;
                  hand = succ(hand, n);
               end else if (modified[hand]) begin
                  done = 1'b1;
               end else begin
                  hand = succ(hand, n);
               end
            end
         end
      end
   endfunction

   function void note_access(cpr_pkg::req_type a);
      int n, f;
      bit found;
      cpr_pkg::rsp_type r;
      n = ring_len();
      if (hand >= n) hand = 0;
      r = '0;
      found = 1'b0;
      f = hand;
      for (int k = 0; k < n; k++) begin
         if (!found) begin
            if (occupied[f] && page_at[f] == a.page_number) found = 1'b1;
            else f = succ(f, n);
         end
      end
      if (found) begin
         referenced[f] = 1'b1;
         if (a.is_write) modified[f] = 1'b1;
         r.hit = 1'b1;
         r.frame_index = f[cpr_pkg::FIDX_W-1:0];
         expected_outcomes.push_back(r);
         return;
      end
      f = hand;
      for (int k = 0; k < n; k++) begin
         if (!found) begin
            if (!occupied[f]) found = 1'b1;
            else f = succ(f, n);
         end
      end
      if (!found) begin
         if (enhanced) walk_enhanced(n);
         else walk_plain(n);
         f = hand;
         r.evicted = 1'b1;
         r.victim_page = page_at[f];
         r.victim_dirty = modified[f];
      end
      page_at[f]    = a.page_number;
      occupied[f]   = 1'b1;
      referenced[f] = 1'b1;
      modified[f]   = a.is_write;
      r.frame_index = f[cpr_pkg::FIDX_W-1:0];
      expected_outcomes.push_back(r);
   endfunction

   function void check_result(cpr_pkg::rsp_type got);
      cpr_pkg::rsp_type want;
      if (expected_outcomes.size() == 0) begin
         errors++;
         $error("result word with nothing expected: %h", got);
         return;
      end
      want = expected_outcomes.pop_front();
      n_checked++;
      if (want.hit) n_hits++;
      if (want.evicted) n_evicted++;
      if (want.victim_dirty) n_dirty++;
      if (got.hit !== want.hit) begin
         errors++;
         $error("hit: expected %0d, got %0d", want.hit, got.hit);
      end
      if (got.frame_index !== want.frame_index) begin
         errors++;
         $error("frame_index: expected %0d, got %0d", want.frame_index, got.frame_index);
      end
      if (got.evicted !== want.evicted) begin
         errors++;
         $error("evicted: expected %0d, got %0d", want.evicted, got.evicted);
      end
      if (got.victim_page !== want.victim_page) begin
         errors++;
         $error("victim_page: expected %h, got %h", want.victim_page, got.victim_page);
      end
      if (got.victim_dirty !== want.victim_dirty) begin
         errors++;
         $error("victim_dirty: expected %0d, got %0d", want.victim_dirty, got.victim_dirty);
      end
   endfunction

   function int pending();
      return expected_outcomes.size();
   endfunction

endclass

module tb_top;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_ready;
   cpr_pkg::req_type                    req_data = '0;
   logic                                rsp_valid;
   logic                                rsp_ready = 1'b0;
   cpr_pkg::rsp_type                    rsp_data;
   logic                                csr_we = 1'b0;
   logic [cpr_pkg::CSR_IDX_W-1:0]       csr_index = '0;
   logic [cpr_pkg::CSR_DATA_W-1:0]      csr_wdata = '0;

   replacement_tracker                  board = new();
   int                                  stall_pct = 0;
   int unsigned                         hold_cycles = 0;
   int                                  n_settings = 0;
   logic [cpr_pkg::PAGE_FIELD_W-1:0]    page_pool [128];
   int                                  pool_len = 1;

   clock_page_replacement_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #15_000_000;
      $display("tb_top: FAIL");
      $finish;
   end

   // long receiver hold-off, counted down here
   always @(posedge clock) begin
      if (hold_cycles != 0) hold_cycles <= hold_cycles - 1;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) board.check_result(rsp_data);
         rsp_ready <= (hold_cycles == 0) && ($urandom_range(0, 99) >= stall_pct);
      end
   end

   function automatic cpr_pkg::req_type access(input logic [cpr_pkg::PAGE_FIELD_W-1:0] p,
                                               input logic w);
      cpr_pkg::req_type a;
      a.page_number = p;
      a.is_write = w;
      return a;
   endfunction

   task automatic send_access(input cpr_pkg::req_type a);
      req_valid <= 1'b1;
      req_data <= a;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_access(a);
   endtask

   task automatic wait_drained();
      while (board.pending() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [cpr_pkg::CSR_IDX_W-1:0] idx,
                            input logic [cpr_pkg::CSR_DATA_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      board.apply_reg(idx, val);
   endtask

   // upper data bits of the mode word are junk the block must ignore
   task automatic reconfigure(input bit enh, input logic [cpr_pkg::FIU_W-1:0] ring);
      req_valid <= 1'b0;
      wait_drained();
      write_reg(cpr_pkg::CSR_ENHANCED_MODE, {6'($urandom_range(0, 63)), enh});
      write_reg(cpr_pkg::CSR_FRAMES_IN_USE, ring);
      csr_we <= 1'b0;
      n_settings++;
   endtask

   task automatic run_phase(input bit enh, input logic [cpr_pkg::FIU_W-1:0] ring,
                            input int items, input int send_idle, input int recv_stall,
                            input int hold);
      int eff, wr_pct, i;
      cpr_pkg::req_type a;
      reconfigure(enh, ring);
      eff = (ring == 0) ? 1 : (ring > cpr_pkg::NUM_FRAMES) ? cpr_pkg::NUM_FRAMES : int'(ring);
      pool_len = eff + eff / 2 + 1;
      for (i = 0; i < pool_len; i++) begin
         page_pool[i] = ($urandom_range(0, 3) == 0) ? 20'(i) : 20'($urandom);
      end
      wr_pct = $urandom_range(10, 70);
      stall_pct = recv_stall;
      if (hold != 0) hold_cycles <= hold;
      for (i = 0; i < items; i++) begin
         if (send_idle != 0 && $urandom_range(0, 99) < send_idle) begin
            req_valid <= 1'b0;
            do @(posedge clock); while ($urandom_range(0, 99) < send_idle);
         end
         a.page_number = ($urandom_range(0, 99) < 85) ?
                         page_pool[$urandom_range(0, pool_len - 1)] : 20'($urandom);
         a.is_write = ($urandom_range(0, 99) < wr_pct);
         send_access(a);
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: plain clock over all frames
      send_access(access(20'h00000, 1'b1));
      send_access(access(20'hFFFFF, 1'b0));
      send_access(access(20'h00000, 1'b0));

      // two-frame ring, full: second chance clears both refs then wraps
      reconfigure(1'b0, 7'd2);
      send_access(access(20'hAAAAA, 1'b1));
      send_access(access(20'h55555, 1'b0));
      send_access(access(20'hAAAAA, 1'b0));

      // enhanced: fill three frames then force both victim passes
      reconfigure(1'b1, 7'd3);
      send_access(access(20'h00001, 1'b0));
      send_access(access(20'h00002, 1'b1));
      send_access(access(20'h00003, 1'b0));
      send_access(access(20'h00004, 1'b1));
      send_access(access(20'h00002, 1'b0));
      send_access(access(20'h00005, 1'b0));
      send_access(access(20'h00006, 1'b1));

      // shrink so the hand lands outside the ring
      reconfigure(1'b1, 7'd1);
      send_access(access(20'h7FFFF, 1'b1));
      send_access(access(20'h80000, 1'b0));
      send_access(access(20'h80000, 1'b1));

      // zero ring size behaves as one frame
      reconfigure(1'b0, 7'd0);
      send_access(access(20'h00007, 1'b0));
      send_access(access(20'h7FFFF, 1'b0));

      // oversize ring clamps to all frames; older frames come back into view
      reconfigure(1'b0, 7'd127);
      send_access(access(20'h55555, 1'b0));
      send_access(access(20'hFFFFF, 1'b1));
      send_access(access(20'h00003, 1'b1));

      run_phase(1'b0, 7'd4,   200,  0,  0,   0);
      run_phase(1'b1, 7'd8,   250, 46,  0,   0);
      run_phase(1'b0, 7'd1,   100,  0, 46,   0);
      run_phase(1'b1, 7'd0,    60, 25, 25,   0);
      run_phase(1'b1, 7'd16,  300, 25, 25,   0);
      run_phase(1'b0, 7'd100, 120,  0,  0,   0);
      run_phase(1'b1, 7'd64,  120, 46,  0,   0);
      run_phase(1'b0, 7'd127,  60,  0, 46,   0);
      run_phase(1'b1, 7'd3,   200,  0,  0, 400);
      run_phase(1'b0, 7'd12,  250, 25, 25,   0);
      run_phase(1'b1, 7'd5,   200,  0, 46,   0);
      run_phase(1'b0, 7'd2,    40, 46, 46,   0);

      req_valid <= 1'b0;
      wait_drained();
      repeat (400) @(posedge clock);

      $display("tb_top: %0d accesses checked over %0d ring/mode settings",
               board.n_checked, n_settings);
      $display("tb_top: %0d hits, %0d evictions (%0d of them dirty)",
               board.n_hits, board.n_evicted, board.n_dirty);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
